// ----- design/dfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfc_pkg
// Shared types, constants and the CRC-16 byte step for the descriptor frame
// checker.
// ----------------------------------------------------------------------------
package dfc_pkg;

  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [31:0] MAGIC_WORD    = 32'h41524442;
  localparam logic [7:0]  VERSION_CODE  = 8'd3;
  localparam int unsigned HDR_BYTES     = 10;
  localparam int unsigned CRC_BYTES     = 2;
  localparam int unsigned MIN_FRAME     = HDR_BYTES + CRC_BYTES;

  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned CFG_INDEX_W   = 3;

  localparam logic [7:0]  JPEG_TYPE_RST      = 8'd4;
  localparam logic [7:0]  BOOLEAN_TYPE_RST   = 8'd1;
  localparam logic [15:0] MAX_PAYLOAD_RST    = 16'd64;
  localparam logic [15:0] MAX_IMAGE_RST      = 16'd16384;
  localparam logic [7:0]  MAX_TOPIC_RST      = 8'd64;
  localparam logic [7:0]  MAX_NAME_RST       = 8'd32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_JPEG_TYPE    = 3'd0,
    CFG_BOOLEAN_TYPE = 3'd1,
    CFG_MAX_PAYLOAD  = 3'd2,
    CFG_MAX_IMAGE    = 3'd3,
    CFG_MAX_TOPIC    = 3'd4,
    CFG_MAX_NAME     = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_MALFORMED = 2'd1,
    VERDICT_REJECTED  = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } dfc_in_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  visual_kind;
    logic [15:0] declared_size;
    logic [7:0]  topic_len;
    logic [7:0]  name_len;
    logic [31:0] malformed_total;
    logic [31:0] rejected_total;
  } dfc_out_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] m;
    case (pos)
      2'd0:    m = MAGIC_WORD[31:24];
      2'd1:    m = MAGIC_WORD[23:16];
      2'd2:    m = MAGIC_WORD[15:8];
      default: m = MAGIC_WORD[7:0];
    endcase
    return m;
  endfunction

endpackage

// ----- design/descriptor_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_frame_checker
// Byte-serial descriptor frame checker with CRC-16 and header validation.
// ----------------------------------------------------------------------------
// Takes one frame byte per transfer and gives one verdict transfer for the
// byte marked frame_end. A byte is taken every cycle while the result side
// keeps up; a frame's result passes through the one input register and
// then the one result register. The CRC runs one byte per cycle while bytes
// are taken, through an unrolled eight-bit update, which sets the critical
// path together with the verdict compare. Bytes that do not end a frame keep
// flowing while a finished verdict waits on out_ready. Configuration must be
// written only while no frame is in flight; the block does not enforce this.
module descriptor_frame_checker
  import dfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dfc_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dfc_out_t               out_data,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration
  logic [7:0]  jpeg_type;
  logic [7:0]  boolean_type;
  logic [15:0] max_payload;
  logic [15:0] max_image;
  logic [7:0]  max_topic;
  logic [7:0]  max_name;

  // input register
  logic        s_valid;
  dfc_in_t     s_data;
  logic        s_go;

  // per-frame state
  logic [15:0] crc_acc, crc_acc_next;
  logic [7:0]  held0, held0_next;
  logic [7:0]  held1, held1_next;
  logic [15:0] byte_index, byte_index_next;
  logic        magic_ok, magic_ok_next;
  logic [7:0]  kind_reg, kind_reg_next;
  logic [15:0] size_reg, size_reg_next;
  logic [7:0]  topic_reg, topic_reg_next;
  logic [7:0]  name_reg, name_reg_next;
  logic        zero_seen, zero_seen_next;
  logic [31:0] malformed_count, malformed_count_next;
  logic [31:0] rejected_count, rejected_count_next;

  logic [15:0] crc_step;
  logic        zero_step;
  logic [16:0] frame_len;
  logic [9:0]  need_len;
  logic [15:0] limit;
  logic [15:0] expect_crc;
  verdict_t    verdict;
  dfc_out_t    result;

  assign s_go     = s_valid && (!s_data.frame_end || !out_valid || out_ready);
  assign in_ready = !s_valid || s_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      jpeg_type    <= JPEG_TYPE_RST;
      boolean_type <= BOOLEAN_TYPE_RST;
      max_payload  <= MAX_PAYLOAD_RST;
      max_image    <= MAX_IMAGE_RST;
      max_topic    <= MAX_TOPIC_RST;
      max_name     <= MAX_NAME_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_JPEG_TYPE:    jpeg_type    <= cfg_data[7:0];
        CFG_BOOLEAN_TYPE: boolean_type <= cfg_data[7:0];
        CFG_MAX_PAYLOAD:  max_payload  <= cfg_data;
        CFG_MAX_IMAGE:    max_image    <= cfg_data;
        CFG_MAX_TOPIC:    max_topic    <= cfg_data[7:0];
        CFG_MAX_NAME:     max_name     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_data <= in_data;
    end
  end

  always_comb begin
    magic_ok_next  = magic_ok;
    kind_reg_next  = kind_reg;
    size_reg_next  = size_reg;
    topic_reg_next = topic_reg;
    name_reg_next  = name_reg;

    // header decode
    if (byte_index < 16'd4) begin
      if (s_data.frame_byte != magic_byte(byte_index[1:0])) begin
        magic_ok_next = 1'b0;
      end
    end else if (byte_index == 16'd4) begin
      if (s_data.frame_byte != VERSION_CODE) begin
        magic_ok_next = 1'b0;
      end
    end else if (byte_index == 16'd5) begin
      kind_reg_next = s_data.frame_byte;
    end else if (byte_index == 16'd6) begin
      size_reg_next = {s_data.frame_byte, size_reg[7:0]};
    end else if (byte_index == 16'd7) begin
      size_reg_next = {size_reg[15:8], s_data.frame_byte};
    end else if (byte_index == 16'd8) begin
      topic_reg_next = s_data.frame_byte;
    end else if (byte_index == 16'd9) begin
      name_reg_next = s_data.frame_byte;
    end

    // byte leaving the two-byte delay line
    crc_step  = crc_acc;
    zero_step = zero_seen;
    if (byte_index >= 16'(CRC_BYTES)) begin
      crc_step = crc_byte(crc_acc, held0);
      if (byte_index >= 16'(MIN_FRAME) && held0 == 8'd0) begin
        zero_step = 1'b1;
      end
    end

    // verdict at frame end
    frame_len  = {1'b0, byte_index} + 17'd1;
    need_len   = 10'(HDR_BYTES) + {2'b00, topic_reg} + {2'b00, name_reg} + 10'(CRC_BYTES);
    limit      = (kind_reg == jpeg_type) ? max_image : max_payload;
    expect_crc = {held1, s_data.frame_byte};

    if (frame_len < 17'(MIN_FRAME) || crc_step != expect_crc) begin
      verdict = VERDICT_MALFORMED;
    end else if (!magic_ok || size_reg > limit ||
                 (kind_reg == boolean_type && size_reg != 16'd1) ||
                 topic_reg == 8'd0 || topic_reg > max_topic ||
                 name_reg == 8'd0 || name_reg > max_name ||
                 frame_len != 17'(need_len) || zero_step) begin
      verdict = VERDICT_REJECTED;
    end else begin
      verdict = VERDICT_OK;
    end

    malformed_count_next = malformed_count;
    rejected_count_next  = rejected_count;
    if (s_data.frame_end) begin
      if (verdict == VERDICT_MALFORMED) begin
        malformed_count_next = malformed_count + 32'd1;
      end else if (verdict == VERDICT_REJECTED) begin
        rejected_count_next = rejected_count + 32'd1;
      end
    end

    result                 = '0;
    result.verdict         = verdict;
    result.malformed_total = malformed_count_next;
    result.rejected_total  = rejected_count_next;
    if (verdict == VERDICT_OK) begin
      result.visual_kind   = kind_reg;
      result.declared_size = size_reg;
      result.topic_len     = topic_reg;
      result.name_len      = name_reg;
    end

    // next frame state
    if (s_data.frame_end) begin
      crc_acc_next    = CRC_INIT;
      held0_next      = 8'd0;
      held1_next      = 8'd0;
      byte_index_next = 16'd0;
      magic_ok_next   = 1'b1;
      kind_reg_next   = 8'd0;
      size_reg_next   = 16'd0;
      topic_reg_next  = 8'd0;
      name_reg_next   = 8'd0;
      zero_seen_next  = 1'b0;
    end else begin
      crc_acc_next    = crc_step;
      held0_next      = held1;
      held1_next      = s_data.frame_byte;
      byte_index_next = (byte_index == 16'hFFFF) ? byte_index : byte_index + 16'd1;
      zero_seen_next  = zero_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc         <= CRC_INIT;
      held0           <= 8'd0;
      held1           <= 8'd0;
      byte_index      <= 16'd0;
      magic_ok        <= 1'b1;
      kind_reg        <= 8'd0;
      size_reg        <= 16'd0;
      topic_reg       <= 8'd0;
      name_reg        <= 8'd0;
      zero_seen       <= 1'b0;
      malformed_count <= 32'd0;
      rejected_count  <= 32'd0;
    end else if (s_go) begin
      crc_acc         <= crc_acc_next;
      held0           <= held0_next;
      held1           <= held1_next;
      byte_index      <= byte_index_next;
      magic_ok        <= magic_ok_next;
      kind_reg        <= kind_reg_next;
      size_reg        <= size_reg_next;
      topic_reg       <= topic_reg_next;
      name_reg        <= name_reg_next;
      zero_seen       <= zero_seen_next;
      malformed_count <= malformed_count_next;
      rejected_count  <= rejected_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_go && s_data.frame_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_go && s_data.frame_end) begin
      out_data <= result;
    end
  end

endmodule
